>>> src/slr_pkg.sv
// Shared types, constants and helper functions for the stroke line rasterizer.
// No dependencies; every other file of the block imports this package.
package slr_pkg;

  localparam int unsigned GRID_SIZE   = 28;
  localparam int unsigned CELL_PIXELS = 7;
  localparam int unsigned IDX_W       = $clog2(GRID_SIZE);

  localparam int unsigned COORD_W  = 9;
  localparam int unsigned SUM_W    = COORD_W + 1;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ROWIX_W  = 5;
  localparam int unsigned ROW_W    = 28;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned CNT_MAX  = 1023;
  localparam int unsigned CNT_TOP  = (GRID_SIZE * GRID_SIZE < CNT_MAX) ?
                                     GRID_SIZE * GRID_SIZE : CNT_MAX;

  // Bresenham error term and its doubled form
  localparam int unsigned ERR_W = COORD_W + 3;
  localparam int unsigned E2_W  = ERR_W + 1;

  // divide by CELL_PIXELS through a reciprocal, at most one low
  localparam int unsigned DIV_S   = 16;
  localparam int unsigned DIV_M   = (1 << DIV_S) / CELL_PIXELS;
  localparam int unsigned DIV_M_W = DIV_S + 1;
  localparam int unsigned PROD_W  = COORD_W + DIV_M_W;
  localparam int unsigned QC_W    = COORD_W + 5;

  // command queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT = 2'd2;
  localparam logic [COORD_W-1:0] LEFT_RST   = 9'd20;
  localparam logic [COORD_W-1:0] TOP_RST    = 9'd20;
  localparam logic [COORD_W-1:0] EXTENT_RST = 9'd192;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_LINE   = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] extent;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [ROWIX_W-1:0] row;
    logic               acc;
  } cmd_t;

  // final quotient from the reciprocal estimate: bump by one if remainder >= divisor
  function automatic logic [COORD_W-1:0] cell_fix(logic [COORD_W-1:0] off,
                                                  logic [COORD_W-1:0] q);
    logic [QC_W-1:0] qc;
    logic [QC_W-1:0] r;
    qc = QC_W'(q) * QC_W'(CELL_PIXELS);
    r  = QC_W'(off) - qc;
    if (r >= QC_W'(CELL_PIXELS)) begin
      return q + 1'b1;
    end
    return q;
  endfunction

  // low columns of a grid row, zero padded for narrow grids
  function automatic logic [ROW_W-1:0] to_row(logic [GRID_SIZE-1:0] g);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 0; i < ROW_W && i < GRID_SIZE; i++) begin
      r[i] = g[i];
    end
    return r;
  endfunction

endpackage

>>> src/slr_front.sv
// Front end: accepts input words, checks samples against the canvas and keeps
// the last pen point. Emits one command per word. Depends on slr_pkg.
module slr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slr_pkg::cfg_t                 cfg_i,
  input  logic                          push_i,
  input  logic [slr_pkg::KIND_W-1:0]    kind_i,
  input  logic [slr_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [slr_pkg::COORD_W-1:0]   pos_y_i,
  input  logic [slr_pkg::ROWIX_W-1:0]   row_index_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output slr_pkg::cmd_t                 q_cmd_o
);
  import slr_pkg::*;

  logic               last_valid_q, last_valid_d;
  logic [COORD_W-1:0] last_x_q, last_y_q;
  logic [SUM_W-1:0]   right_edge, bottom_edge;
  logic               in_canvas, accept, take_point;

  assign accept      = push_i && !q_full_i;
  assign right_edge  = {1'b0, cfg_i.left} + {1'b0, cfg_i.extent};
  assign bottom_edge = {1'b0, cfg_i.top} + {1'b0, cfg_i.extent};
  // strict bounds for samples
  assign in_canvas = (pos_x_i > cfg_i.left) && ({1'b0, pos_x_i} < right_edge) &&
                     (pos_y_i > cfg_i.top) && ({1'b0, pos_y_i} < bottom_edge);

  always_comb begin
    q_cmd_o.op  = OP_REPORT;
    q_cmd_o.x0  = pos_x_i;
    q_cmd_o.y0  = pos_y_i;
    q_cmd_o.x1  = pos_x_i;
    q_cmd_o.y1  = pos_y_i;
    q_cmd_o.row = row_index_i;
    q_cmd_o.acc = 1'b0;
    last_valid_d = last_valid_q;
    take_point   = 1'b0;
    unique case (kind_e'(kind_i))
      KIND_DOWN: begin
        if (in_canvas) begin
          q_cmd_o.op  = OP_LINE;
          q_cmd_o.acc = 1'b1;
          // no held point: a zero length line marks just this pixel
          if (last_valid_q) begin
            q_cmd_o.x0 = last_x_q;
            q_cmd_o.y0 = last_y_q;
          end
          last_valid_d = 1'b1;
          take_point   = 1'b1;
        end
      end
      KIND_UP: begin
        last_valid_d = 1'b0;
      end
      KIND_CLEAR: begin
        q_cmd_o.op   = OP_CLEAR;
        last_valid_d = 1'b0;
      end
      KIND_READ: begin
        q_cmd_o.op = OP_READ;
      end
      default: begin
        q_cmd_o.op = OP_REPORT;
      end
    endcase
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
    end else if (accept) begin
      last_valid_q <= last_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && take_point) begin
      last_x_q <= pos_x_i;
      last_y_q <= pos_y_i;
    end
  end

endmodule

>>> src/slr_queue.sv
// Short command queue decoupling front and back.
// Depends on slr_pkg for the command type and depth.
module slr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  slr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output slr_pkg::cmd_t cmd_o
);
  import slr_pkg::*;

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_q, rp_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  function automatic logic [Q_PTR_W-1:0] ptr_next(logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= ptr_next(wp_q);
      end
      if (do_pop) begin
        rp_q <= ptr_next(rp_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

>>> src/slr_back.sv
// Back end: walks lines one pixel a cycle, maps pixels to cells in a three
// stage pipeline, owns the bitmap and the result register. Depends on slr_pkg.
module slr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slr_pkg::cfg_t               cfg_i,
  input  logic                        cmd_valid_i,
  input  slr_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  input  logic                        res_pop_i,
  output logic                        res_valid_o,
  output logic [slr_pkg::ROW_W-1:0]   row_bits_o,
  output logic [slr_pkg::CNT_W-1:0]   set_count_o,
  output logic                        accepted_o
);
  import slr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // held command
  op_e                op_q;
  logic [ROWIX_W-1:0] row_q;
  logic               acc_q;

  // line walker
  logic [COORD_W-1:0]      wx_q, wy_q, ex_q, ey_q, dx_q, dy_q;
  logic                    sx_neg_q, sy_neg_q;
  logic signed [ERR_W-1:0] err_q;
  logic [COORD_W-1:0]      ld_dx, ld_dy;
  logic signed [E2_W-1:0]  e2, dx_s, dy_s;
  logic                    step_x, step_y, at_end, walk_load, walk_step;

  // cell pipeline
  logic               p1v_q, p2v_q, p3v_q;
  logic [COORD_W-1:0] p1x_q, p1y_q;
  logic               p2in_q, p3in_q;
  logic [COORD_W-1:0] p2ox_q, p2oy_q, p3ox_q, p3oy_q, p3qx_q, p3qy_q;
  logic [PROD_W-1:0]  p2mx_q, p2my_q;
  logic [SUM_W-1:0]   right_edge, bottom_edge;
  logic               p1_in;
  logic [COORD_W-1:0] p1_ox, p1_oy, cx, cy;

  // bitmap
  logic [GRID_SIZE-1:0] grid_q [GRID_SIZE];
  logic [CNT_W-1:0]     cnt_q;
  logic [SUM_W-1:0]     rd_sel;
  logic                 rd_ok, hit, mark, clear_go;
  logic [GRID_SIZE-1:0] row_data;

  // result register
  logic               res_valid_q, res_load;
  logic [ROW_W-1:0]   res_row_q;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               res_acc_q;

  // ---- control ----
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    walk_load = 1'b0;
    walk_step = 1'b0;
    clear_go  = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_LINE) begin
            walk_load = 1'b1;
            state_d   = ST_WALK;
          end else begin
            clear_go = (cmd_i.op == OP_CLEAR);
            state_d  = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (at_end) begin
          state_d = ST_DRAIN;
        end else begin
          walk_step = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!p1v_q && !p2v_q && !p3v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid_q || res_pop_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      op_q  <= cmd_i.op;
      row_q <= cmd_i.row;
      acc_q <= cmd_i.acc;
    end
  end

  // ---- Bresenham walker ----
  assign ld_dx  = (cmd_i.x1 > cmd_i.x0) ? cmd_i.x1 - cmd_i.x0 : cmd_i.x0 - cmd_i.x1;
  assign ld_dy  = (cmd_i.y1 > cmd_i.y0) ? cmd_i.y1 - cmd_i.y0 : cmd_i.y0 - cmd_i.y1;
  assign at_end = (wx_q == ex_q) && (wy_q == ey_q);
  assign e2     = {err_q, 1'b0};
  assign dx_s   = E2_W'(dx_q);
  assign dy_s   = E2_W'(dy_q);
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;

  always_ff @(posedge clk_i) begin
    if (walk_load) begin
      wx_q     <= cmd_i.x0;
      wy_q     <= cmd_i.y0;
      ex_q     <= cmd_i.x1;
      ey_q     <= cmd_i.y1;
      dx_q     <= ld_dx;
      dy_q     <= ld_dy;
      sx_neg_q <= !(cmd_i.x0 < cmd_i.x1);
      sy_neg_q <= !(cmd_i.y0 < cmd_i.y1);
      err_q    <= ERR_W'(ld_dx) - ERR_W'(ld_dy);
    end else if (walk_step) begin
      err_q <= err_q - (step_x ? ERR_W'(dy_q) : '0) + (step_y ? ERR_W'(dx_q) : '0);
      if (step_x) begin
        wx_q <= sx_neg_q ? wx_q - 1'b1 : wx_q + 1'b1;
      end
      if (step_y) begin
        wy_q <= sy_neg_q ? wy_q - 1'b1 : wy_q + 1'b1;
      end
    end
  end

  // ---- pixel to cell pipeline ----
  assign right_edge  = {1'b0, cfg_i.left} + {1'b0, cfg_i.extent};
  assign bottom_edge = {1'b0, cfg_i.top} + {1'b0, cfg_i.extent};
  assign p1_in = (p1x_q >= cfg_i.left) && ({1'b0, p1x_q} < right_edge) &&
                 (p1y_q >= cfg_i.top) && ({1'b0, p1y_q} < bottom_edge);
  assign p1_ox = p1x_q - cfg_i.left;
  assign p1_oy = p1y_q - cfg_i.top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q <= 1'b0;
      p2v_q <= 1'b0;
      p3v_q <= 1'b0;
    end else begin
      p1v_q <= (state_q == ST_WALK);
      p2v_q <= p1v_q;
      p3v_q <= p2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1x_q  <= wx_q;
    p1y_q  <= wy_q;
    p2in_q <= p1_in;
    p2ox_q <= p1_ox;
    p2oy_q <= p1_oy;
    p2mx_q <= PROD_W'(p1_ox) * PROD_W'(DIV_M);
    p2my_q <= PROD_W'(p1_oy) * PROD_W'(DIV_M);
    p3in_q <= p2in_q;
    p3ox_q <= p2ox_q;
    p3oy_q <= p2oy_q;
    p3qx_q <= p2mx_q[DIV_S +: COORD_W];
    p3qy_q <= p2my_q[DIV_S +: COORD_W];
  end

  assign cx = cell_fix(p3ox_q, p3qx_q);
  assign cy = cell_fix(p3oy_q, p3qy_q);

  // ---- bitmap: one row address, shared by marking and row reads ----
  assign rd_sel   = p3v_q ? {1'b0, cy} : SUM_W'(row_q);
  assign rd_ok    = rd_sel < SUM_W'(GRID_SIZE);
  assign row_data = rd_ok ? grid_q[rd_sel[IDX_W-1:0]] : '0;
  assign hit  = p3v_q && p3in_q && (cx < COORD_W'(GRID_SIZE)) && (cy < COORD_W'(GRID_SIZE));
  assign mark = hit && !row_data[cx[IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        grid_q[i] <= '0;
      end
      cnt_q <= '0;
    end else if (clear_go) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        grid_q[i] <= '0;
      end
      cnt_q <= '0;
    end else if (mark) begin
      grid_q[rd_sel[IDX_W-1:0]][cx[IDX_W-1:0]] <= 1'b1;
      if (cnt_q != CNT_W'(CNT_MAX)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_row_q <= (op_q == OP_READ && rd_ok) ? to_row(row_data) : '0;
      res_cnt_q <= cnt_q;
      res_acc_q <= acc_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign row_bits_o  = res_row_q;
  assign set_count_o = res_cnt_q;
  assign accepted_o  = res_acc_q;

endmodule

>>> src/stroke_line_rasterizer_grid.sv
// Top level of the stroke line rasterizer: configuration registers, front,
// command queue and back. Depends on slr_pkg, slr_front, slr_queue, slr_back.
//
// Usage:
//  - Input words (kind, pos_x, pos_y, row_index) enter on push while full is
//    low. Every word yields exactly one result word (row_bits, set_count,
//    accepted), delivered in order on the output side: it is valid while
//    empty is low and is taken when pop is high.
//  - Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0 canvas_left, 1 canvas_top, 2 canvas_extent); other indexes are
//    ignored. Write only while the block is idle.
//  - Pen-up, clear, read and rejected samples skip the line walk. An accepted
//    sample walks N = max(|dx|, |dy|) + 1 pixels on the line (1 for a first
//    point); the line walker steps one pixel per cycle, so N, up to 511, sets
//    the rate.
//  - A two-word command queue lets the front keep accepting while the back
//    walks a line; full rises only when both entries are taken.
//  - If the receiver stalls, the finished result waits in the output register,
//    the back holds its next result, and the queue fills, then full rises.
//  - Reset clears the bitmap, the set count, the held pen point and all queues,
//    and loads the canvas registers with 20, 20 and 192.
module stroke_line_rasterizer_grid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [slr_pkg::COORD_W-1:0]     cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic [slr_pkg::KIND_W-1:0]      kind_i,
  input  logic [slr_pkg::COORD_W-1:0]     pos_x_i,
  input  logic [slr_pkg::COORD_W-1:0]     pos_y_i,
  input  logic [slr_pkg::ROWIX_W-1:0]     row_index_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [slr_pkg::ROW_W-1:0]       row_bits_o,
  output logic [slr_pkg::CNT_W-1:0]       set_count_o,
  output logic                            accepted_o
);
  import slr_pkg::*;

  cfg_t cfg_q;
  logic q_push, q_full, cmd_valid, cmd_pop, res_valid, res_pop;
  cmd_t q_cmd, cmd;

  // canvas registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left   <= LEFT_RST;
      cfg_q.top    <= TOP_RST;
      cfg_q.extent <= EXTENT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEFT: begin
          cfg_q.left <= cfg_wdata_i;
        end
        CFG_TOP: begin
          cfg_q.top <= cfg_wdata_i;
        end
        CFG_EXTENT: begin
          cfg_q.extent <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // front: classify words, track the pen point
  slr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .kind_i      (kind_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .row_index_i (row_index_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  slr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd)
  );

  // back: line walk, bitmap, result register
  slr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (res_pop),
    .res_valid_o (res_valid),
    .row_bits_o  (row_bits_o),
    .set_count_o (set_count_o),
    .accepted_o  (accepted_o)
  );

  assign full    = q_full;
  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

  // only pen-down words can be accepted, and those never return a row
  a_acc_no_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && accepted_o) |-> (row_bits_o == '0))
    else $error("accepted result carries row bits");

  // the set count cannot pass the number of cells
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (set_count_o <= CNT_W'(CNT_TOP)))
    else $error("set count beyond grid size");

  // a full queue always presents a command to the back
  a_full_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> cmd_valid)
    else $error("queue full but no command offered");

  // a command is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("push into full command queue");

endmodule
